// ----- rtl/core/cspc_pkg.sv -----
`timescale 1ns / 1ps

package cspc_pkg;

  localparam int unsigned RATE_BITS  = 16;
  localparam int unsigned QUO_BITS   = 20;
  localparam int unsigned DIV_STEPS  = QUO_BITS;
  localparam logic [QUO_BITS-1:0] RATE_NUM = 20'd1000000;
  localparam logic [RATE_BITS-1:0] RATE_MAX = 16'hFFFF;

  localparam logic [1:0] ACT_CAPTURE  = 2'd0;
  localparam logic [1:0] ACT_SWITCH   = 2'd1;
  localparam logic [1:0] ACT_CLASSIFY = 2'd2;

  localparam logic [1:0] FILT_RED   = 2'd0;
  localparam logic [1:0] FILT_BLUE  = 2'd1;
  localparam logic [1:0] FILT_CLEAR = 2'd2;
  localparam logic [1:0] FILT_GREEN = 2'd3;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;
  localparam logic [1:0] CHAN_NONE  = 2'd3;

  localparam logic [1:0] CLS_DARK  = 2'd0;
  localparam logic [1:0] CLS_RED   = 2'd1;
  localparam logic [1:0] CLS_GREEN = 2'd2;
  localparam logic [1:0] CLS_BLUE  = 2'd3;

  localparam logic [1:0] REG_TIMER_TOP  = 2'd0;
  localparam logic [1:0] REG_DARK_THR   = 2'd1;
  localparam logic [1:0] REG_BLUE_RATIO = 2'd2;

  typedef logic [RATE_BITS-1:0] rate_t;

endpackage

// ----- rtl/core/color_sensor_period_classifier.sv -----
`timescale 1ns / 1ps

// Color sensor period classifier. Each input item is a capture (timer stamp of a
// sensor edge), a filter switch, or a classify request, and returns exactly one
// result item. A capture with a nonzero period runs a radix-2 restoring divider
// that produces one quotient bit per cycle, then the block finishes and loads
// the output register; a capture with zero period, a switch, a classify or an
// unused action goes straight from accept to finish and output load. One item
// is processed at a time; s_tready is high only while the block is idle, and a
// result waits in the output register until taken.

module color_sensor_period_classifier import cspc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] capture_value
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [15:0] rate_value, [17:16] rate_channel,
                                 // [18] rate_saturated, [20:19] filter_select,
                                 // [22:21] color_class, [23] zero
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state;

  rate_t      timer_top;
  rate_t      dark_thr;
  logic [7:0] blue_ratio;

  rate_t      prev_stamp;
  logic [1:0] chan_idx;
  rate_t      red_rate;
  rate_t      green_rate;
  rate_t      blue_rate;
  logic [1:0] cur_filter;

  rate_t      pend_rate;
  logic [1:0] pend_chan;
  logic       pend_sat;
  logic [1:0] pend_class;

  logic                accept;
  rate_t               period;
  logic [1:0]          cap_chan;
  logic                div_start;
  logic                div_done;
  logic [QUO_BITS-1:0] div_quo;
  logic                quo_ovf;
  rate_t               quo_rate;
  logic [1:0]          cls_calc;
  logic [19:0]         green_x10;
  logic [23:0]         red_x_ratio;
  logic                out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (s_tdata >= prev_stamp) begin
      period = s_tdata - prev_stamp;
    end else begin
      period = timer_top - prev_stamp + s_tdata + 16'd1;
    end
  end

  // the index was advanced by the switch that chose the filter
  always_comb begin
    unique case (chan_idx)
      2'd1:    cap_chan = CHAN_RED;
      2'd2:    cap_chan = CHAN_GREEN;
      default: cap_chan = CHAN_BLUE;
    endcase
  end

  assign green_x10   = {1'b0, green_rate, 3'b000} + {3'b000, green_rate, 1'b0};
  assign red_x_ratio = red_rate * blue_ratio;

  always_comb begin
    if (red_rate < dark_thr && green_rate < dark_thr && blue_rate < dark_thr) begin
      cls_calc = CLS_DARK;
    end else if (red_rate > green_rate && red_rate > blue_rate) begin
      cls_calc = CLS_RED;
    end else if ({4'b0000, green_x10} > red_x_ratio) begin
      cls_calc = CLS_BLUE;
    end else begin
      cls_calc = CLS_GREEN;
    end
  end

  assign div_start = accept && (s_tuser == ACT_CAPTURE) && (period != '0);
  assign quo_ovf   = |div_quo[QUO_BITS-1:RATE_BITS];
  assign quo_rate  = quo_ovf ? RATE_MAX : div_quo[RATE_BITS-1:0];

  cspc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (period),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_top  <= RATE_MAX;
      dark_thr   <= 16'd120;
      blue_ratio <= 8'd19;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TIMER_TOP:  timer_top  <= cfg_data;
        REG_DARK_THR:   dark_thr   <= cfg_data;
        REG_BLUE_RATIO: blue_ratio <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prev_stamp <= '0;
      chan_idx   <= 2'd0;
      red_rate   <= '0;
      green_rate <= '0;
      blue_rate  <= '0;
      cur_filter <= FILT_CLEAR;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_FIN;
            unique case (s_tuser)
              ACT_CAPTURE: begin
                prev_stamp <= s_tdata;
                if (period == '0) begin
                  unique case (cap_chan)
                    CHAN_RED:   red_rate   <= RATE_MAX;
                    CHAN_GREEN: green_rate <= RATE_MAX;
                    default:    blue_rate  <= RATE_MAX;
                  endcase
                end else begin
                  state <= ST_DIV;
                end
              end
              ACT_SWITCH: begin
                unique case (chan_idx)
                  2'd0:    cur_filter <= FILT_RED;
                  2'd1:    cur_filter <= FILT_GREEN;
                  default: cur_filter <= FILT_BLUE;
                endcase
                prev_stamp <= '0;
                chan_idx   <= (chan_idx == 2'd2) ? 2'd0 : chan_idx + 2'd1;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIN;
            unique case (pend_chan)
              CHAN_RED:   red_rate   <= quo_rate;
              CHAN_GREEN: green_rate <= quo_rate;
              default:    blue_rate  <= quo_rate;
            endcase
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_rate  <= '0;
      pend_chan  <= CHAN_NONE;
      pend_sat   <= 1'b0;
      pend_class <= CLS_DARK;
      unique case (s_tuser)
        ACT_CAPTURE: begin
          pend_chan <= cap_chan;
          if (period == '0) begin
            pend_rate <= RATE_MAX;
            pend_sat  <= 1'b1;
          end
        end
        ACT_CLASSIFY: pend_class <= cls_calc;
        default: ;
      endcase
    end else if (state == ST_DIV && div_done) begin
      pend_rate <= quo_rate;
      pend_sat  <= quo_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_tdata <= {1'b0, pend_class, cur_filter, pend_sat, pend_chan, pend_rate};
    end
  end

endmodule

// ----- rtl/core/cspc_div.sv -----
`timescale 1ns / 1ps

module cspc_div import cspc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rate_t               divisor,
  output logic                done,
  output logic [QUO_BITS-1:0] quotient
);

  localparam int unsigned CNT_BITS = $clog2(DIV_STEPS);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIV_STEPS - 1);

  logic                running;
  logic [CNT_BITS-1:0] count;
  rate_t               rem;
  rate_t               dvs;
  logic [QUO_BITS-1:0] num;
  logic [QUO_BITS-1:0] quo;

  logic [RATE_BITS:0] rem_sh;
  logic [RATE_BITS:0] rem_diff;
  logic               fits;

  assign rem_sh   = {rem, num[QUO_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + CNT_BITS'(1);
        if (count == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      num <= RATE_NUM;
      quo <= '0;
    end else if (running) begin
      num <= {num[QUO_BITS-2:0], 1'b0};
      quo <= {quo[QUO_BITS-2:0], fits};
      if (fits) begin
        rem <= rem_diff[RATE_BITS-1:0];
      end else begin
        rem <= rem_sh[RATE_BITS-1:0];
      end
    end
  end

endmodule
